>>> rtl/aalt_pkg.sv
// Shared types and constants for the axis-angle to local transform pipeline.
package aalt_pkg;

  localparam int ROT_W  = 24;
  localparam int OFS_W  = 32;
  localparam int MAT_W  = 24;
  localparam int THR_W  = 23;
  localparam int ROOT_W = 24;
  localparam int SQ_W   = 48;

  localparam logic [THR_W-1:0] THR_RESET = 23'd105;

  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [MAT_W-1:0] ONE_Q22 = 24'h40_0000;
  localparam logic [31:0] QPI_Q28   = 32'd210828714;
  localparam logic [31:0] HPI_Q28   = 32'd421657428;
  localparam logic [31:0] TWOPI_Q28 = 32'd1686629713;
  localparam logic [31:0] TWOPI2_Q28 = 32'd3373259426;

  // Taylor divisors, sine chain first, cosine chain second
  localparam int unsigned POLY_DIV [0:1][0:4] = '{
    '{110, 72, 42, 20, 6},
    '{132, 90, 56, 30, 12}
  };
  localparam logic [63:0] TWO_POW32 = 64'd1 << 32;
  localparam logic [31:0] POLY_RCP [0:1][0:4] = '{
    '{32'(TWO_POW32 / 64'd110), 32'(TWO_POW32 / 64'd72), 32'(TWO_POW32 / 64'd42),
      32'(TWO_POW32 / 64'd20), 32'(TWO_POW32 / 64'd6)},
    '{32'(TWO_POW32 / 64'd132), 32'(TWO_POW32 / 64'd90), 32'(TWO_POW32 / 64'd56),
      32'(TWO_POW32 / 64'd30), 32'(TWO_POW32 / 64'd12)}
  };

  // Side data that rides along with each word
  typedef struct packed {
    logic signed [OFS_W-1:0] ofs_x;
    logic signed [OFS_W-1:0] ofs_y;
    logic signed [OFS_W-1:0] ofs_z;
    logic                    near_zero;
    logic signed [31:0]      u_x;
    logic signed [31:0]      u_y;
    logic signed [31:0]      u_z;
  } pass_t;

endpackage

>>> rtl/axis_angle_to_local_transform.sv
// Top level: axis-angle rotation vector and joint offset to a 3x4 local transform.
//
// Fully pipelined: a new word may be started in every clock cycle, and busy
// never rises. Each word gives one result on done_o; the pipeline depth is set
// by the square root (one root bit per stage) and the three-lane divider (one
// quotient bit per stage) that lie in series ahead of the sine/cosine chain
// and the matrix stages. Results cannot be held off, so the receiver must
// take every done_o pulse. Write the small-angle threshold only while the
// pipeline is empty.
module axis_angle_to_local_transform (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [aalt_pkg::THR_W-1:0]   cfg_data_i,
  input  logic signed [aalt_pkg::ROT_W-1:0]   rot_x_i,
  input  logic signed [aalt_pkg::ROT_W-1:0]   rot_y_i,
  input  logic signed [aalt_pkg::ROT_W-1:0]   rot_z_i,
  input  logic signed [aalt_pkg::OFS_W-1:0]   offset_x_i,
  input  logic signed [aalt_pkg::OFS_W-1:0]   offset_y_i,
  input  logic signed [aalt_pkg::OFS_W-1:0]   offset_z_i,
  output logic                                done_o,
  output logic signed [aalt_pkg::MAT_W-1:0]   r00_o,
  output logic signed [aalt_pkg::MAT_W-1:0]   r01_o,
  output logic signed [aalt_pkg::MAT_W-1:0]   r02_o,
  output logic signed [aalt_pkg::MAT_W-1:0]   r10_o,
  output logic signed [aalt_pkg::MAT_W-1:0]   r11_o,
  output logic signed [aalt_pkg::MAT_W-1:0]   r12_o,
  output logic signed [aalt_pkg::MAT_W-1:0]   r20_o,
  output logic signed [aalt_pkg::MAT_W-1:0]   r21_o,
  output logic signed [aalt_pkg::MAT_W-1:0]   r22_o,
  output logic signed [aalt_pkg::OFS_W-1:0]   trans_x_o,
  output logic signed [aalt_pkg::OFS_W-1:0]   trans_y_o,
  output logic signed [aalt_pkg::OFS_W-1:0]   trans_z_o
);
  import aalt_pkg::*;

  logic [THR_W-1:0]  thr_q;
  pass_t             pass_in, pass_n, pass_v, pass_s;
  logic              vld_n, vld_v, vld_s;
  logic signed [ROT_W-1:0] wx_n, wy_n, wz_n;
  logic [ROOT_W-1:0] norm_n, norm_v;
  logic signed [31:0] sin_s, cos_s;
  logic signed [MAT_W-1:0] r_m [9];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  assign pass_in = '{ofs_x: offset_x_i, ofs_y: offset_y_i, ofs_z: offset_z_i,
                     near_zero: 1'b0, u_x: '0, u_y: '0, u_z: '0};

  aalt_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .rot_x_i (rot_x_i),
    .rot_y_i (rot_y_i),
    .rot_z_i (rot_z_i),
    .pass_i  (pass_in),
    .thr_i   (thr_q),
    .valid_o (vld_n),
    .rot_x_o (wx_n),
    .rot_y_o (wy_n),
    .rot_z_o (wz_n),
    .norm_o  (norm_n),
    .pass_o  (pass_n)
  );

  aalt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_n),
    .rot_x_i (wx_n),
    .rot_y_i (wy_n),
    .rot_z_i (wz_n),
    .norm_i  (norm_n),
    .pass_i  (pass_n),
    .valid_o (vld_v),
    .norm_o  (norm_v),
    .pass_o  (pass_v)
  );

  aalt_sincos u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_v),
    .norm_i  (norm_v),
    .pass_i  (pass_v),
    .valid_o (vld_s),
    .sin_o   (sin_s),
    .cos_o   (cos_s),
    .pass_o  (pass_s)
  );

  aalt_mat u_mat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vld_s),
    .sin_i     (sin_s),
    .cos_i     (cos_s),
    .pass_i    (pass_s),
    .valid_o   (done_o),
    .r_o       (r_m),
    .trans_x_o (trans_x_o),
    .trans_y_o (trans_y_o),
    .trans_z_o (trans_z_o)
  );

  assign r00_o = r_m[0];
  assign r01_o = r_m[1];
  assign r02_o = r_m[2];
  assign r10_o = r_m[3];
  assign r11_o = r_m[4];
  assign r12_o = r_m[5];
  assign r20_o = r_m[6];
  assign r21_o = r_m[7];
  assign r22_o = r_m[8];

endmodule

>>> rtl/aalt_norm.sv
// Vector norm: squares, sum and a pipelined integer square root, one root bit per stage; flags small norms.
module aalt_norm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [aalt_pkg::ROT_W-1:0]   rot_x_i,
  input  logic signed [aalt_pkg::ROT_W-1:0]   rot_y_i,
  input  logic signed [aalt_pkg::ROT_W-1:0]   rot_z_i,
  input  aalt_pkg::pass_t                     pass_i,
  input  logic        [aalt_pkg::THR_W-1:0]   thr_i,
  output logic                                valid_o,
  output logic signed [aalt_pkg::ROT_W-1:0]   rot_x_o,
  output logic signed [aalt_pkg::ROT_W-1:0]   rot_y_o,
  output logic signed [aalt_pkg::ROT_W-1:0]   rot_z_o,
  output logic        [aalt_pkg::ROOT_W-1:0]  norm_o,
  output aalt_pkg::pass_t                     pass_o
);
  import aalt_pkg::*;

  localparam int NSTEP = ROOT_W;
  localparam int LAST  = NSTEP + 3;
  localparam int REM_W = ROOT_W + 3;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
    pass_t                   p;
  } nl_t;

  logic        vld_q [0:LAST];
  nl_t         nl_q  [0:LAST];
  nl_t         nl_in;
  logic [ROT_W-1:0]  mag_d [3];
  logic [ROT_W-1:0]  mag_q [3];
  logic [SQ_W-1:0]   sqr_q [3];
  logic [SQ_W-1:0]   s_q    [0:NSTEP];
  logic [REM_W-1:0]  rem_q  [0:NSTEP];
  logic [REM_W-1:0]  rem_d  [1:NSTEP];
  logic [ROOT_W-1:0] root_q [0:NSTEP];
  logic [ROOT_W-1:0] root_d [1:NSTEP];
  logic [ROOT_W-1:0] n_q;
  logic              small_q;

  always_comb begin
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] tst;
    nl_in = '{x: rot_x_i, y: rot_y_i, z: rot_z_i, p: pass_i};
    mag_d[0] = rot_x_i[ROT_W-1] ? $unsigned(-rot_x_i) : $unsigned(rot_x_i);
    mag_d[1] = rot_y_i[ROT_W-1] ? $unsigned(-rot_y_i) : $unsigned(rot_y_i);
    mag_d[2] = rot_z_i[ROT_W-1] ? $unsigned(-rot_z_i) : $unsigned(rot_z_i);
    for (int k = 0; k < NSTEP; k++) begin
      // bring down the next two radicand bits and try root*4+1
      sh  = {rem_q[k][REM_W-3:0], s_q[k][SQ_W-1-2*k -: 2]};
      tst = {1'b0, root_q[k], 2'b01};
      if (sh >= tst) begin
        rem_d[k+1]  = sh - tst;
        root_d[k+1] = {root_q[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[k+1]  = sh;
        root_d[k+1] = {root_q[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LAST; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i <= LAST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    nl_q[0] <= nl_in;
    for (int i = 1; i <= LAST; i++) nl_q[i] <= nl_q[i-1];
    for (int l = 0; l < 3; l++) begin
      mag_q[l] <= mag_d[l];
      sqr_q[l] <= SQ_W'(mag_q[l]) * SQ_W'(mag_q[l]);
    end
    s_q[0]    <= sqr_q[0] + sqr_q[1] + sqr_q[2];
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    for (int k = 1; k <= NSTEP; k++) begin
      s_q[k]    <= s_q[k-1];
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
    end
    n_q     <= root_q[NSTEP];
    small_q <= root_q[NSTEP] <= ROOT_W'(thr_i);
  end

  always_comb begin
    pass_o           = nl_q[LAST].p;
    pass_o.near_zero = small_q;
  end

  assign valid_o = vld_q[LAST];
  assign rot_x_o = nl_q[LAST].x;
  assign rot_y_o = nl_q[LAST].y;
  assign rot_z_o = nl_q[LAST].z;
  assign norm_o  = n_q;

endmodule

>>> rtl/aalt_div.sv
// Unit vector: three lanes of pipelined restoring division w * 2^30 / n.
module aalt_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [aalt_pkg::ROT_W-1:0]   rot_x_i,
  input  logic signed [aalt_pkg::ROT_W-1:0]   rot_y_i,
  input  logic signed [aalt_pkg::ROT_W-1:0]   rot_z_i,
  input  logic        [aalt_pkg::ROOT_W-1:0]  norm_i,
  input  aalt_pkg::pass_t                     pass_i,
  output logic                                valid_o,
  output logic        [aalt_pkg::ROOT_W-1:0]  norm_o,
  output aalt_pkg::pass_t                     pass_o
);
  import aalt_pkg::*;

  localparam int NQ   = 31;
  localparam int LAST = NQ + 1;

  typedef struct packed {
    logic [ROOT_W-1:0] norm;
    pass_t             pass;
    logic [2:0]        neg;
  } dm_t;

  logic              vld_q [0:LAST];
  dm_t               dm_q  [0:LAST];
  dm_t               dm_in;
  logic [ROOT_W-1:0] p_q [3][0:NQ];
  logic [ROOT_W-1:0] p_d [3][1:NQ];
  logic [NQ-1:0]     q_q [3][0:NQ];
  logic [NQ-1:0]     q_d [3][1:NQ];
  logic              b0_q [3];
  logic signed [31:0] u_q [3];
  logic signed [ROT_W-1:0] w_in [3];
  logic [ROT_W-1:0]  wm [3];

  always_comb begin
    logic [ROOT_W:0] pn;
    logic [ROOT_W:0] nn;
    w_in[0] = rot_x_i;
    w_in[1] = rot_y_i;
    w_in[2] = rot_z_i;
    for (int l = 0; l < 3; l++) begin
      wm[l] = w_in[l][ROT_W-1] ? $unsigned(-w_in[l]) : $unsigned(w_in[l]);
    end
    dm_in = '{norm: norm_i, pass: pass_i,
              neg: {w_in[2][ROT_W-1], w_in[1][ROT_W-1], w_in[0][ROT_W-1]}};
    for (int l = 0; l < 3; l++) begin
      for (int i = 0; i < NQ; i++) begin
        // only the top quotient step sees a dividend bit; the rest shift in zero
        pn = {p_q[l][i], (i == 0) ? b0_q[l] : 1'b0};
        nn = {1'b0, dm_q[i].norm};
        if (pn >= nn) begin
          p_d[l][i+1] = ROOT_W'(pn - nn);
          q_d[l][i+1] = {q_q[l][i][NQ-2:0], 1'b1};
        end else begin
          p_d[l][i+1] = ROOT_W'(pn);
          q_d[l][i+1] = {q_q[l][i][NQ-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LAST; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i <= LAST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dm_q[0] <= dm_in;
    for (int i = 1; i <= LAST; i++) dm_q[i] <= dm_q[i-1];
    for (int l = 0; l < 3; l++) begin
      p_q[l][0] <= {1'b0, wm[l][ROT_W-1:1]};
      q_q[l][0] <= '0;
      b0_q[l]   <= wm[l][0];
      for (int i = 1; i <= NQ; i++) begin
        p_q[l][i] <= p_d[l][i];
        q_q[l][i] <= q_d[l][i];
      end
      u_q[l] <= dm_q[NQ].neg[l] ? -$signed({1'b0, q_q[l][NQ]})
                                :  $signed({1'b0, q_q[l][NQ]});
    end
  end

  always_comb begin
    pass_o     = dm_q[LAST].pass;
    pass_o.u_x = u_q[0];
    pass_o.u_y = u_q[1];
    pass_o.u_z = u_q[2];
  end

  assign valid_o = vld_q[LAST];
  assign norm_o  = dm_q[LAST].norm;

endmodule

>>> rtl/aalt_sincos.sv
// Sine and cosine of the norm: range reduction, two Taylor chains, quadrant fix.
module aalt_sincos (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic        [aalt_pkg::ROOT_W-1:0]  norm_i,
  input  aalt_pkg::pass_t                     pass_i,
  output logic                                valid_o,
  output logic signed [31:0]                  sin_o,
  output logic signed [31:0]                  cos_o,
  output aalt_pkg::pass_t                     pass_o
);
  import aalt_pkg::*;

  localparam int NPOLY = 5;
  localparam int PBASE = 6;
  localparam int LAST  = PBASE + 3 * NPOLY + 2;

  typedef struct packed {
    logic [29:0] x2;
    logic [29:0] ay;
    logic        neg;
    logic [1:0]  quad;
  } mt_t;

  logic        vld_q  [0:LAST];
  pass_t       pass_q [0:LAST];
  logic [31:0] r1_q, r_q, r2_q;
  logic [2:0]  k_q;
  logic signed [31:0] y_q;
  logic [1:0]  quad3_q, quad4_q;
  logic [29:0] ay4_q;
  logic        neg4_q;
  mt_t         mt_q [PBASE-1:LAST-1];
  logic [30:0] v_q  [2][0:NPOLY-1];
  logic [30:0] vh_q [2][0:NPOLY-1];
  logic [30:0] qe_q [2][0:NPOLY-1];
  logic [30:0] t_q  [2][0:NPOLY-1];
  logic [30:0] v_d  [2][1:NPOLY-1];
  logic [30:0] qe_d [2][0:NPOLY-1];
  logic [30:0] t_d  [2][0:NPOLY-1];
  logic [30:0] ps_q, pc_q;
  logic signed [31:0] s_q, c_q, sin_q, cos_q;
  logic [31:0] a_d, r1_d, r_d, tq_d, kh_d;
  logic [2:0]  k_d;
  logic signed [31:0] y_d;
  logic [31:0] ym_d;

  always_comb begin
    logic [38:0] rm;
    a_d  = {norm_i, 8'd0};
    r1_d = (a_d >= TWOPI2_Q28) ? a_d - TWOPI2_Q28 : a_d;
    r_d  = (r1_q >= TWOPI_Q28) ? r1_q - TWOPI_Q28 : r1_q;
    tq_d = r_q + QPI_Q28;
    k_d  = {2'b00, tq_d >= HPI_Q28} + {2'b00, tq_d >= 32'(HPI_Q28 * 2)}
         + {2'b00, tq_d >= 32'(HPI_Q28 * 3)} + {2'b00, tq_d >= 32'(HPI_Q28 * 4)};
    case (k_q)
      3'd1:    kh_d = HPI_Q28;
      3'd2:    kh_d = 32'(HPI_Q28 * 2);
      3'd3:    kh_d = 32'(HPI_Q28 * 3);
      3'd4:    kh_d = 32'(HPI_Q28 * 4);
      default: kh_d = '0;
    endcase
    y_d  = $signed(r2_q) - $signed(kh_d);
    ym_d = y_q[31] ? $unsigned(-y_q) : $unsigned(y_q);
    for (int c = 0; c < 2; c++) begin
      for (int j = 1; j < NPOLY; j++) begin
        v_d[c][j] = 31'((61'(mt_q[PBASE+3*j-1].x2) * 61'(t_q[c][j-1])) >> 30);
      end
      for (int j = 0; j < NPOLY; j++) begin
        // reciprocal estimate is exact or one low: fix with one compare
        qe_d[c][j] = 31'((63'(v_q[c][j]) * 63'(POLY_RCP[c][j])) >> 32);
        rm = 39'(vh_q[c][j]) - 39'(qe_q[c][j]) * 39'(POLY_DIV[c][j]);
        t_d[c][j] = 31'(ONE_Q30) - (qe_q[c][j] + 31'(rm >= 39'(POLY_DIV[c][j])));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LAST; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i <= LAST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q[0] <= pass_i;
    for (int i = 1; i <= LAST; i++) pass_q[i] <= pass_q[i-1];
    r1_q    <= r1_d;
    r_q     <= r_d;
    r2_q    <= r_q;
    k_q     <= k_d;
    y_q     <= y_d;
    quad3_q <= k_q[1:0];
    ay4_q   <= {ym_d[27:0], 2'b00};
    neg4_q  <= y_q[31];
    quad4_q <= quad3_q;
    mt_q[PBASE-1] <= '{x2: 30'((60'(ay4_q) * 60'(ay4_q)) >> 30), ay: ay4_q,
                       neg: neg4_q, quad: quad4_q};
    for (int i = PBASE; i < LAST; i++) mt_q[i] <= mt_q[i-1];
    for (int c = 0; c < 2; c++) begin
      v_q[c][0] <= {1'b0, mt_q[PBASE-1].x2};
      for (int j = 1; j < NPOLY; j++) v_q[c][j] <= v_d[c][j];
      for (int j = 0; j < NPOLY; j++) begin
        vh_q[c][j] <= v_q[c][j];
        qe_q[c][j] <= qe_d[c][j];
        t_q[c][j]  <= t_d[c][j];
      end
    end
    ps_q <= 31'((61'(mt_q[LAST-3].ay) * 61'(t_q[0][NPOLY-1])) >> 30);
    pc_q <= 31'((61'(mt_q[LAST-3].x2) * 61'(t_q[1][NPOLY-1])) >> 30);
    s_q  <= mt_q[LAST-2].neg ? -$signed({1'b0, ps_q}) : $signed({1'b0, ps_q});
    c_q  <= $signed(ONE_Q30) - $signed({2'b00, pc_q[30:1]});
    case (mt_q[LAST-1].quad)
      2'd0:    begin sin_q <= s_q;  cos_q <= c_q;  end
      2'd1:    begin sin_q <= c_q;  cos_q <= -s_q; end
      2'd2:    begin sin_q <= -s_q; cos_q <= -c_q; end
      default: begin sin_q <= -c_q; cos_q <= s_q;  end
    endcase
  end

  assign valid_o = vld_q[LAST];
  assign pass_o  = pass_q[LAST];
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

>>> rtl/aalt_mat.sv
// Rotation matrix assembly from unit vector, sine and cosine, with rounding to Q2.22.
module aalt_mat (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [31:0]                 sin_i,
  input  logic signed [31:0]                 cos_i,
  input  aalt_pkg::pass_t                    pass_i,
  output logic                               valid_o,
  output logic signed [aalt_pkg::MAT_W-1:0]  r_o [9],
  output logic signed [aalt_pkg::OFS_W-1:0]  trans_x_o,
  output logic signed [aalt_pkg::OFS_W-1:0]  trans_y_o,
  output logic signed [aalt_pkg::OFS_W-1:0]  trans_z_o
);
  import aalt_pkg::*;

  localparam int LAST = 6;
  // off-diagonal entries in row-major order 01 02 10 12 20 21
  localparam int OD_IDX [6]  = '{1, 2, 3, 5, 6, 7};
  localparam int OD_LANE [6] = '{2, 1, 2, 0, 1, 0};
  localparam bit OD_NEG [6]  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam int OD_PAIR [6] = '{0, 1, 0, 2, 1, 2};
  localparam int PA [3] = '{0, 0, 1};
  localparam int PB [3] = '{1, 2, 2};

  logic        vld_q  [0:LAST];
  pass_t       pass_q [0:LAST];
  logic signed [31:0] u_in [3];
  logic [30:0] mu_q [3];
  logic        nu_q [3];
  logic [30:0] ms_q;
  logic        ns_q;
  logic [31:0] c1a_q, c1b_q, c1c_q;
  logic [30:0] sq_q [3], cr_q [3], us_q [3], cr2_q [3];
  logic        crn_q [3], usn_q [3], crn2_q [3], crn3_q [3];
  logic [31:0] dm_q [3];
  logic signed [31:0] uss_q [3];
  logic [32:0] pd_q [3], pc_q [3];
  logic signed [31:0] kt_q [6];
  logic signed [34:0] v_q [9];
  logic [34:0] vm_q [9];
  logic        vn_q [9];
  logic signed [MAT_W-1:0] r_q [9];
  logic [26:0] m_d [9];
  logic [27:0] sv_d [9];
  logic signed [MAT_W-1:0] r_d [9];

  always_comb begin
    // unit vector enters beside sine and cosine of the same word
    u_in[0] = pass_i.u_x;
    u_in[1] = pass_i.u_y;
    u_in[2] = pass_i.u_z;
    for (int e = 0; e < 9; e++) begin
      m_d[e]  = 27'((vm_q[e] + 35'd128) >> 8);
      sv_d[e] = vn_q[e] ? 28'd0 - {1'b0, m_d[e]} : {1'b0, m_d[e]};
      if (vn_q[e] && m_d[e] > 27'd8388608)       r_d[e] = -24'sd8388608;
      else if (!vn_q[e] && m_d[e] > 27'd8388607) r_d[e] = 24'sd8388607;
      else                                       r_d[e] = $signed(sv_d[e][MAT_W-1:0]);
      // small angle: force identity
      if (pass_q[LAST-1].near_zero) begin
        r_d[e] = (e == 0 || e == 4 || e == 8) ? $signed(ONE_Q22) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LAST; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i <= LAST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q[0] <= pass_i;
    for (int i = 1; i <= LAST; i++) pass_q[i] <= pass_q[i-1];
    // take magnitudes
    for (int l = 0; l < 3; l++) begin
      mu_q[l] <= 31'(u_in[l][31] ? $unsigned(-u_in[l]) : $unsigned(u_in[l]));
      nu_q[l] <= u_in[l][31];
    end
    ms_q  <= 31'(sin_i[31] ? $unsigned(-sin_i) : $unsigned(sin_i));
    ns_q  <= sin_i[31];
    c1a_q <= 32'($signed({1'b0, ONE_Q30}) - 33'(cos_i));
    // first products
    for (int l = 0; l < 3; l++) begin
      sq_q[l]  <= 31'((62'(mu_q[l]) * 62'(mu_q[l])) >> 30);
      us_q[l]  <= 31'((62'(mu_q[l]) * 62'(ms_q)) >> 30);
      usn_q[l] <= nu_q[l] ^ ns_q;
      cr_q[l]  <= 31'((62'(mu_q[PA[l]]) * 62'(mu_q[PB[l]])) >> 30);
      crn_q[l] <= nu_q[PA[l]] ^ nu_q[PB[l]];
    end
    c1b_q <= c1a_q;
    // diagonal sums, signed sine terms
    for (int l = 0; l < 3; l++) begin
      dm_q[l]   <= 32'(sq_q[(l+1)%3]) + 32'(sq_q[(l+2)%3]);
      uss_q[l]  <= usn_q[l] ? -$signed({1'b0, us_q[l]}) : $signed({1'b0, us_q[l]});
      cr2_q[l]  <= cr_q[l];
      crn2_q[l] <= crn_q[l];
    end
    c1c_q <= c1b_q;
    // products with 1 - cos
    for (int l = 0; l < 3; l++) begin
      pd_q[l]   <= 33'((64'(dm_q[l]) * 64'(c1c_q)) >> 30);
      pc_q[l]   <= 33'((64'(cr2_q[l]) * 64'(c1c_q)) >> 30);
      crn3_q[l] <= crn2_q[l];
    end
    for (int o = 0; o < 6; o++) begin
      kt_q[o] <= OD_NEG[o] ? -uss_q[OD_LANE[o]] : uss_q[OD_LANE[o]];
    end
    // entry values in Q1.30
    for (int l = 0; l < 3; l++) begin
      v_q[4*l] <= 35'sd1073741824 - $signed({2'b00, pd_q[l]});
    end
    for (int o = 0; o < 6; o++) begin
      v_q[OD_IDX[o]] <= 35'(kt_q[o])
        + (crn3_q[OD_PAIR[o]] ? -$signed({2'b00, pc_q[OD_PAIR[o]]})
                              :  $signed({2'b00, pc_q[OD_PAIR[o]]}));
    end
    for (int e = 0; e < 9; e++) begin
      vm_q[e] <= v_q[e][34] ? $unsigned(-v_q[e]) : $unsigned(v_q[e]);
      vn_q[e] <= v_q[e][34];
      r_q[e]  <= r_d[e];
    end
  end

  assign valid_o   = vld_q[LAST];
  assign r_o       = r_q;
  assign trans_x_o = pass_q[LAST].ofs_x;
  assign trans_y_o = pass_q[LAST].ofs_y;
  assign trans_z_o = pass_q[LAST].ofs_z;

endmodule
